/* design/dib_pkg.sv */
`timescale 1ns / 1ps
package dib_pkg;

	// Field widths
	localparam int POS_W  = 28;
	localparam int SIZE_W = 21;
	localparam int DI_W   = 33;

	// Config port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Counter width and index fraction
	localparam int COUNT_BITS = 24;
	localparam int FRAC_BITS  = 8;

	// Serial arithmetic widths
	localparam int SQ_W  = 2 * COUNT_BITS;
	localparam int NUM_W = SQ_W + FRAC_BITS;
	localparam int QUO_W = COUNT_BITS + FRAC_BITS;
	localparam int MAG_W = QUO_W + 1;
	localparam int CMP_W = (MAG_W > DI_W) ? MAG_W : DI_W + 1;

	// Index saturation limits
	localparam logic [63:0] DI_POS_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] DI_NEG_MAX = 64'h0000_0001_0000_0000;

	// Register reset values
	localparam logic [POS_W-1:0]  ORIGIN_RST = 28'd0;
	localparam logic [SIZE_W-1:0] SIZE_RST   = 21'd40000;
	localparam logic [POS_W-1:0]  MAXD_RST   = 28'd2000000;

	typedef enum logic [1:0] {
		REG_WINDOW_ORIGIN = 2'd0,
		REG_WINDOW_SIZE   = 2'd1,
		REG_MAX_DISTANCE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                  start;
		logic                  neg;
		logic [COUNT_BITS:0]   sum;
	} div_req_t;

endpackage

/* design/dib_sqr.sv */
`timescale 1ns / 1ps
module dib_sqr (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dib_pkg::COUNT_BITS-1:0]  d,
	output logic                            done,
	output logic [dib_pkg::SQ_W-1:0]        prod
);
	import dib_pkg::*;

	localparam int CNT_W = $clog2(COUNT_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COUNT_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COUNT_BITS-1:0] mcand_q;
	logic [COUNT_BITS-1:0] mplier_q;
	logic [SQ_W-1:0]       acc_q;
	logic [COUNT_BITS:0]   add_v;
	logic [COUNT_BITS:0]   hi_sum;

	// Add the multiplicand into the upper half when the low multiplier bit is set
	always_comb begin
		add_v  = mplier_q[0] ? {1'b0, mcand_q} : '0;
		hi_sum = {1'b0, acc_q[SQ_W-1:COUNT_BITS]} + add_v;
	end

	// Sequence one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift partial product right, retire one multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= d;
			mplier_q <= d;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= {hi_sum, acc_q[COUNT_BITS-1:1]};
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* design/dib_div.sv */
`timescale 1ns / 1ps
module dib_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dib_pkg::div_req_t               req,
	input  logic [dib_pkg::SQ_W-1:0]        sq,
	output logic                            done,
	output logic signed [dib_pkg::DI_W-1:0] di
);
	import dib_pkg::*;

	localparam int DCNT_W = $clog2(NUM_W);
	localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(NUM_W - 1);

	logic                     busy_q;
	logic                     fin_q;
	logic                     done_q;
	logic [DCNT_W-1:0]        cnt_q;
	logic [NUM_W-1:0]         num_q;
	logic [COUNT_BITS:0]      rem_q;
	logic [COUNT_BITS:0]      s_q;
	logic [QUO_W-1:0]         quot_q;
	logic                     neg_q;
	logic signed [DI_W-1:0]   di_q;

	logic [COUNT_BITS+1:0]    trial;
	logic                     qbit;
	logic                     round_up;
	logic [MAG_W-1:0]         mag;
	logic [CMP_W-1:0]         mag_x;
	logic [CMP_W-1:0]         lim;
	logic [CMP_W-1:0]         sat;
	logic [DI_W-1:0]          sat_mag;

	// Restoring step: bring in one numerator bit, try to subtract the sum
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]} - {1'b0, s_q};
		qbit  = ~trial[COUNT_BITS+1];
	end

	// Round half away from zero, clamp, apply sign
	always_comb begin
		round_up = {rem_q, 1'b0} >= {1'b0, s_q};
		mag      = {1'b0, quot_q} + MAG_W'(round_up);
		mag_x    = CMP_W'(mag);
		lim      = neg_q ? CMP_W'(DI_NEG_MAX) : CMP_W'(DI_POS_MAX);
		sat      = (mag_x > lim) ? lim : mag_x;
		sat_mag  = DI_W'(sat);
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: load operands, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= NUM_W'(sq) << FRAC_BITS;
			rem_q  <= '0;
			quot_q <= '0;
			s_q    <= req.sum;
			neg_q  <= req.neg;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= qbit ? trial[COUNT_BITS:0] : {rem_q[COUNT_BITS-1:0], num_q[NUM_W-1]};
			quot_q <= {quot_q[QUO_W-2:0], qbit};
		end
		if (fin_q) begin
			di_q <= neg_q ? (~sat_mag + 1'b1) : sat_mag;
		end
	end

	assign done = done_q;
	assign di   = di_q;

endmodule

/* design/directionality_index_binner_unit.sv */
`timescale 1ns / 1ps
// Channel  | handshake          | word
// ---------+--------------------+------------------------------------------------
// in       | in_valid/in_stall  | read_pos, mate_pos
// out      | out_valid/out_stall| pair_counted, window_closed, closed_window_start,
//          |                    | window_di
// cfg      | APB psel/penable   | window_origin, window_size, max_distance
//
// An item that leaves its window open passes through the evaluation and completion
// states before its result is loaded into the output register.
// An item that closes a window with unequal counts also passes through the
// bit-serial squarer and then the bit-serial divider before completion.
// One item is in flight at a time; in_stall is high from accept until the
// result sits in the output register, and an unread result holds the block.
// Reset clears control state and loads register defaults; no clearing pass.
module directionality_index_binner_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// config port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dib_pkg::ADDR_W-1:0]        paddr,
	input  logic [dib_pkg::DATA_W-1:0]        pwdata,
	output logic [dib_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	// input words
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [dib_pkg::POS_W-1:0]         read_pos,
	input  logic [dib_pkg::POS_W-1:0]         mate_pos,
	// result words
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              pair_counted,
	output logic                              window_closed,
	output logic [dib_pkg::POS_W-1:0]         closed_window_start,
	output logic signed [dib_pkg::DI_W-1:0]   window_di
);
	import dib_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_SQR  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                 state_q;

	// config registers
	logic [POS_W-1:0]       origin_q;
	logic [SIZE_W-1:0]      size_q;
	logic [POS_W-1:0]       maxd_q;

	// window state
	logic [POS_W-1:0]       start_q;
	logic [COUNT_BITS-1:0]  up_q;
	logic [COUNT_BITS-1:0]  dn_q;

	// captured item and pending result
	logic [POS_W-1:0]       rd_q;
	logic [POS_W-1:0]       mt_q;
	logic                   counted_q;
	logic                   closed_q;
	logic [POS_W-1:0]       cstart_q;
	logic                   neg_q;
	logic [COUNT_BITS:0]    sum_q;
	logic signed [DI_W-1:0] di_res_q;

	// output register
	logic                   out_valid_q;
	logic                   pair_counted_q;
	logic                   window_closed_q;
	logic [POS_W-1:0]       closed_start_q;
	logic signed [DI_W-1:0] window_di_q;

	logic                   cfg_wr;
	reg_idx_t               cfg_idx;
	logic                   accept;
	logic                   out_free;

	logic [POS_W:0]         win_end;
	logic                   close;
	logic                   up_hit;
	logic                   dn_hit;
	logic [COUNT_BITS-1:0]  up_base;
	logic [COUNT_BITS-1:0]  dn_base;
	logic [COUNT_BITS-1:0]  up_next;
	logic [COUNT_BITS-1:0]  dn_next;
	logic                   cnt_neg;
	logic [COUNT_BITS-1:0]  diff;
	logic [COUNT_BITS:0]    cnt_sum;
	logic                   need_div;

	logic                   sqr_start;
	logic                   sqr_done;
	logic [SQ_W-1:0]        sqr_prod;
	div_req_t               div_req;
	logic                   div_done;
	logic signed [DI_W-1:0] div_di;

	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready   = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Register read mux
	always_comb begin
		unique case (cfg_idx)
			REG_WINDOW_ORIGIN: prdata = DATA_W'(origin_q);
			REG_WINDOW_SIZE:   prdata = DATA_W'(size_q);
			REG_MAX_DISTANCE:  prdata = DATA_W'(maxd_q);
			default:           prdata = '0;
		endcase
	end

	// Window close test and mate classification
	always_comb begin
		win_end = {1'b0, start_q} + (POS_W + 1)'(size_q);
		close   = {1'b0, rd_q} >= win_end;
		up_hit  = (mt_q < rd_q) && ((rd_q - mt_q) <= maxd_q);
		dn_hit  = (mt_q > rd_q) && ((mt_q - rd_q) <= maxd_q);
		up_base = close ? '0 : up_q;
		dn_base = close ? '0 : dn_q;
		up_next = (up_hit && !(&up_base)) ? up_base + 1'b1 : up_base;
		dn_next = (dn_hit && !(&dn_base)) ? dn_base + 1'b1 : dn_base;
	end

	// Operands of the index from the counts of the window being closed
	always_comb begin
		cnt_neg  = dn_q < up_q;
		diff     = cnt_neg ? (up_q - dn_q) : (dn_q - up_q);
		cnt_sum  = {1'b0, up_q} + {1'b0, dn_q};
		need_div = close && (up_q != dn_q);
	end

	assign sqr_start     = (state_q == ST_EVAL) && need_div;
	assign div_req.start = sqr_done;
	assign div_req.neg   = neg_q;
	assign div_req.sum   = sum_q;

	dib_sqr u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqr_start),
		.d      (diff),
		.done   (sqr_done),
		.prod   (sqr_prod)
	);

	dib_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sq     (sqr_prod),
		.done   (div_done),
		.di     (div_di)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EVAL;
				ST_EVAL: state_q <= need_div ? ST_SQR : ST_DONE;
				ST_SQR:  if (sqr_done) state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Config registers and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= ORIGIN_RST;
			size_q   <= SIZE_RST;
			maxd_q   <= MAXD_RST;
			start_q  <= ORIGIN_RST;
			up_q     <= '0;
			dn_q     <= '0;
		end else begin
			if (state_q == ST_EVAL) begin
				if (close) begin
					start_q <= win_end[POS_W-1:0];
				end
				up_q <= up_next;
				dn_q <= dn_next;
			end
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_WINDOW_ORIGIN: begin
						origin_q <= pwdata[POS_W-1:0];
						start_q  <= pwdata[POS_W-1:0];
					end
					REG_WINDOW_SIZE:  size_q <= pwdata[SIZE_W-1:0];
					REG_MAX_DISTANCE: maxd_q <= pwdata[POS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Capture the item and the pending result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= read_pos;
			mt_q <= mate_pos;
		end
		if (state_q == ST_EVAL) begin
			counted_q <= up_hit || dn_hit;
			closed_q  <= close;
			cstart_q  <= close ? start_q : '0;
			neg_q     <= cnt_neg;
			sum_q     <= cnt_sum;
			di_res_q  <= '0;
		end
		if ((state_q == ST_DIV) && div_done) begin
			di_res_q <= div_di;
		end
	end

	// Output register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			pair_counted_q  <= counted_q;
			window_closed_q <= closed_q;
			closed_start_q  <= cstart_q;
			window_di_q     <= di_res_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign pair_counted        = pair_counted_q;
	assign window_closed       = window_closed_q;
	assign closed_window_start = closed_start_q;
	assign window_di           = window_di_q;

	// A new result only ever follows the completion state
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result word loaded outside completion state");

	// An open window reports a zero start and a zero index
	a_open_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !window_closed) |-> (window_di == '0 && closed_window_start == '0))
		else $error("nonzero index on a word that closed no window");

	// Squarer finishes only while the sequencer waits for it
	a_sqr_owned: assert property (@(posedge clk) disable iff (!arst_n)
		sqr_done |-> (state_q == ST_SQR))
		else $error("squarer done outside its wait state");

	// Divider finishes only while the sequencer waits for it
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside its wait state");

endmodule

/* test/dib_checker.sv */
`timescale 1ns / 1ps
module dib_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [dib_pkg::ADDR_W-1:0]   paddr,
	input  logic [dib_pkg::DATA_W-1:0]   pwdata,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [dib_pkg::POS_W-1:0]    read_pos,
	input  logic [dib_pkg::POS_W-1:0]    mate_pos,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         pair_counted,
	input  logic                         window_closed,
	input  logic [dib_pkg::POS_W-1:0]    closed_window_start,
	input  logic [dib_pkg::DI_W-1:0]     window_di,
	output int                           outstanding,
	output int                           fail_count
);
	import dib_pkg::*;

	typedef struct packed {
		logic             pair_counted;
		logic             window_closed;
		logic [POS_W-1:0] closed_window_start;
		logic [DI_W-1:0]  window_di;
	} bin_word_t;

	// Own copy of the registers and the window state
	logic [POS_W-1:0]      win_start;
	logic [SIZE_W-1:0]     win_size;
	logic [POS_W-1:0]      max_dist;
	logic [COUNT_BITS-1:0] up_cnt;
	logic [COUNT_BITS-1:0] down_cnt;

	bin_word_t binned_words[$];
	bin_word_t word;

	// DI = (B-A)|B-A|/(A+B) with FRAC_BITS fraction bits, rounded half away from zero
	function automatic logic [DI_W-1:0] index_of_counts(input logic [COUNT_BITS-1:0] a,
		input logic [COUNT_BITS-1:0] b);
		logic [63:0] ua, ub, d, s, sq, r, rem, mag;
		logic        neg;
		ua = a;
		ub = b;
		if (ua == ub)
			return '0;
		neg = ub < ua;
		d = neg ? ua - ub : ub - ua;
		s = ua + ub;
		sq = d * d;
		r = sq % s;
		rem = (r << FRAC_BITS) % s;
		mag = ((sq / s) << FRAC_BITS) + (r << FRAC_BITS) / s;
		if (rem >= s - rem)
			mag = mag + 64'd1;
		if (neg) begin
			if (mag > DI_NEG_MAX)
				mag = DI_NEG_MAX;
			mag = -mag;
		end else if (mag > DI_POS_MAX) begin
			mag = DI_POS_MAX;
		end
		return mag[DI_W-1:0];
	endfunction

	// Close the window if the read reaches its end, then count the mate
	task automatic bin_pair(input logic [POS_W-1:0] rd, input logic [POS_W-1:0] mt,
		output bin_word_t res);
		logic [POS_W:0] win_end;
		res = '0;
		win_end = {1'b0, win_start} + win_size;
		if ({1'b0, rd} >= win_end) begin
			res.window_closed       = 1'b1;
			res.closed_window_start = win_start;
			res.window_di           = index_of_counts(up_cnt, down_cnt);
			win_start = win_start + win_size;
			up_cnt    = '0;
			down_cnt  = '0;
		end
		if (mt < rd && rd - mt <= max_dist) begin
			res.pair_counted = 1'b1;
			if (up_cnt != '1)
				up_cnt = up_cnt + 1'b1;
		end else if (mt > rd && mt - rd <= max_dist) begin
			res.pair_counted = 1'b1;
			if (down_cnt != '1)
				down_cnt = down_cnt + 1'b1;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t  %s  expected %0h  actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start = ORIGIN_RST;
			win_size  = SIZE_RST;
			max_dist  = MAXD_RST;
			up_cnt    = '0;
			down_cnt  = '0;
			binned_words.delete();
			outstanding <= 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_WINDOW_ORIGIN: win_start = pwdata[POS_W-1:0];
					REG_WINDOW_SIZE:   win_size  = pwdata[SIZE_W-1:0];
					REG_MAX_DISTANCE:  max_dist  = pwdata[POS_W-1:0];
					default: ;
				endcase
			end
			// predict the result word of each accepted pair
			if (in_valid && !in_stall) begin
				bin_pair(read_pos, mate_pos, word);
				binned_words.push_back(word);
			end
			// compare each delivered word with the oldest prediction
			if (out_valid && !out_stall) begin
				if (binned_words.size() == 0) begin
					$display("%0t  result word  expected none  actual %0b %0b %0h %0h",
						$time, pair_counted, window_closed, closed_window_start, window_di);
					fail_count++;
				end else begin
					word = binned_words.pop_front();
					check_field("pair_counted", word.pair_counted, pair_counted);
					check_field("window_closed", word.window_closed, window_closed);
					check_field("closed_window_start", word.closed_window_start,
						closed_window_start);
					check_field("window_di", word.window_di, window_di);
				end
			end
			outstanding <= binned_words.size();
		end
	end

endmodule

/* test/tb_directionality_index_binner_unit.sv */
`timescale 1ns / 1ps
module tb_directionality_index_binner_unit;
	import dib_pkg::*;

	localparam logic [1:0]  REG_UNMAPPED = 2'd3;
	localparam int unsigned POS_MAX      = (1 << POS_W) - 1;
	localparam int unsigned SIZE_MAX     = 1048576;
	localparam int          RANDOM_ITEMS = 1300;
	localparam int          RUN_LIMIT    = 1000000;
	localparam int          DRAIN_CYCLES = 120;

	typedef enum logic [1:0] {
		RX_FLOW,
		RX_SPARSE,
		RX_HEAVY
	} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [DATA_W-1:0]      pwdata;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_stall;
	logic [POS_W-1:0]       read_pos;
	logic [POS_W-1:0]       mate_pos;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   pair_counted;
	logic                   window_closed;
	logic [POS_W-1:0]       closed_window_start;
	logic signed [DI_W-1:0] window_di;

	int       outstanding;
	int       fail_count;
	int       burst_left;
	int       items_sent;
	int       cycle_count;
	int       rx_left;
	rx_mode_t rx_mode = RX_FLOW;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	directionality_index_binner_unit i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.read_pos            (read_pos),
		.mate_pos            (mate_pos),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.pair_counted        (pair_counted),
		.window_closed       (window_closed),
		.closed_window_start (closed_window_start),
		.window_di           (window_di)
	);

	dib_checker i_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.pready              (pready),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.read_pos            (read_pos),
		.mate_pos            (mate_pos),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.pair_counted        (pair_counted),
		.window_closed       (window_closed),
		.closed_window_start (closed_window_start),
		.window_di           (window_di),
		.outstanding         (outstanding),
		.fail_count          (fail_count)
	);

	// Stall the result channel in modes that are redrawn whenever a random countdown runs out
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_left <= $urandom_range(10, 150);
				case ($urandom_range(0, 2))
					0: rx_mode <= RX_FLOW;
					1: rx_mode <= RX_SPARSE;
					default: rx_mode <= RX_HEAVY;
				endcase
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_FLOW:   out_stall <= 1'b0;
				RX_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
				default:   out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("directionality_index_binner_unit: mismatch");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_windows(input int unsigned origin, input int unsigned size,
		input int unsigned reach);
		reg_write(REG_WINDOW_SIZE, size);
		reg_write(REG_MAX_DISTANCE, reach);
		reg_write(REG_WINDOW_ORIGIN, origin);
	endtask

	// Offer one pair word; open a new burst after a random gap when the last one ran out
	task automatic send_pair(input logic [POS_W-1:0] rd, input logic [POS_W-1:0] mt);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		read_pos <= rd;
		mate_pos <= mt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned origin, size, reach, span, bias, seq_len, step;
		int          first_random;
		longint      rd, mt, ofs;

		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		read_pos = '0;
		mate_pos = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// default windows: equal mate, far mate, distance edge, closes, skipped windows
		send_pair(28'd0, 28'd0);
		send_pair(28'd0, 28'hFFFFFFF);
		send_pair(28'd100, 28'd50);
		send_pair(28'd200, 28'd2000200);
		send_pair(28'd300, 28'd2000301);
		send_pair(28'd39999, 28'd1);
		send_pair(28'd40000, 28'd40001);
		send_pair(28'd200000, 28'd199999);
		send_pair(28'd200001, 28'd200002);
		send_pair(28'hFFFFFFF, 28'd0);
		settle();

		// window end past the top of the position range, read below window start
		set_windows(28'hFFFFC17, 600, POS_MAX);
		send_pair(28'hFFFFFFF, 28'd0);
		send_pair(28'hFFFFFFF, 28'hFFFFFFE);
		send_pair(28'd5, 28'hFFFFFFF);
		settle();

		// zero window size and zero distance
		set_windows(1000, 0, 0);
		send_pair(28'd999, 28'd0);
		send_pair(28'd1000, 28'd1001);
		send_pair(28'd1000, 28'd1000);
		settle();

		// smallest window and distance; unmapped write must change nothing
		set_windows(0, 1, 1);
		reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
		send_pair(28'd0, 28'd1);
		send_pair(28'd1, 28'd0);
		send_pair(28'd1, 28'd2);
		send_pair(28'd2, 28'd3);
		settle();

		// random sorted runs under random windows, with unsorted pairs mixed in
		first_random = items_sent;
		while (items_sent - first_random < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 9))
				0: size = 1;
				1: size = SIZE_MAX;
				2, 3: size = $urandom_range(2, 64);
				default: size = $urandom_range(65, 4000);
			endcase
			case ($urandom_range(0, 7))
				0: reach = 1;
				1: reach = POS_MAX;
				default: reach = $urandom_range(1, 2 * size + 16);
			endcase
			origin = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, POS_MAX);
			set_windows(origin, size, reach);
			bias    = $urandom_range(0, 100);
			seq_len = $urandom_range(15, 70);
			rd      = origin;
			if ($urandom_range(0, 5) == 0) begin
				ofs = $urandom_range(1, 3 * size);
				rd  = rd - ofs;
				if (rd < 0)
					rd = 0;
			end
			repeat (seq_len) begin
				if ($urandom_range(0, 11) == 0) begin
					send_pair(POS_W'($urandom_range(0, POS_MAX)),
						POS_W'($urandom_range(0, POS_MAX)));
				end else begin
					step = ($urandom_range(0, 19) == 0) ? 3 * size
						: $urandom_range(0, size / 6 + 1);
					rd = rd + step;
					if (rd > POS_MAX)
						rd = POS_MAX;
					case ($urandom_range(0, 11))
						0: ofs = 0;
						1: ofs = reach;
						2: ofs = reach + 1;
						default: begin
							span = (reach > 65536) ? 65536 : reach + 2;
							ofs  = $urandom_range(1, span);
						end
					endcase
					mt = ($urandom_range(0, 99) < bias) ? rd - ofs : rd + ofs;
					if ($urandom_range(0, 19) == 0)
						mt = $urandom_range(0, POS_MAX);
					if (mt < 0)
						mt = 0;
					if (mt > POS_MAX)
						mt = POS_MAX;
					send_pair(rd[POS_W-1:0], mt[POS_W-1:0]);
				end
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("directionality_index_binner_unit: match");
		end else begin
			$display("directionality_index_binner_unit: mismatch");
		end
		$finish;
	end

endmodule

/* files.f */
design/dib_pkg.sv
design/dib_sqr.sv
design/dib_div.sv
design/directionality_index_binner_unit.sv
test/dib_checker.sv
test/tb_directionality_index_binner_unit.sv
